// File: design/smsu_pkg.sv
// shared types and constants of the stable merge sorter unit
// no dependencies; used by smsu_cell and the top level

package smsu_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int KEY_BITS_DEF    = 32;
	localparam int TAG_BITS_DEF    = 16;

	// configuration register indexes
	localparam logic REG_SORT_DESCENDING = 1'b0;
	localparam logic REG_SIGNED_KEYS     = 1'b1;

	// control sequence, one-hot
	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_SORT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	// per-cell control, priority load > take_right > take_left
	typedef struct packed {
		logic load;
		logic take_right;
		logic take_left;
		logic descending;
		logic signed_keys;
	} cell_ctl_t;

endpackage

// File: design/smsu_cell.sv
// one cell of the sorting chain: holds a record, compares it with its right neighbour
// depends on smsu_pkg

module smsu_cell #(
	parameter int KEY_BITS = smsu_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = smsu_pkg::TAG_BITS_DEF
) (
	input  logic                         clk,
	input  smsu_pkg::cell_ctl_t          ctl,
	input  logic [KEY_BITS+TAG_BITS-1:0] load_rec,
	input  logic [KEY_BITS+TAG_BITS-1:0] left_rec,
	input  logic [KEY_BITS+TAG_BITS-1:0] right_rec,
	output logic [KEY_BITS+TAG_BITS-1:0] rec,
	output logic                         gt_right
);

	logic [KEY_BITS+TAG_BITS-1:0] rec_q;
	logic [KEY_BITS-1:0]          ka;
	logic [KEY_BITS-1:0]          kb;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= load_rec;
		end else if (ctl.take_right) begin
			rec_q <= right_rec;
		end else if (ctl.take_left) begin
			rec_q <= left_rec;
		end
	end

	// signed keys compare as unsigned with the sign bit flipped
	always_comb begin
		ka = rec_q[KEY_BITS-1:0];
		kb = right_rec[KEY_BITS-1:0];
		ka[KEY_BITS-1] = rec_q[KEY_BITS-1] ^ ctl.signed_keys;
		kb[KEY_BITS-1] = right_rec[KEY_BITS-1] ^ ctl.signed_keys;
		// strict order only, so equal keys never swap
		gt_right = ctl.descending ? (ka < kb) : (ka > kb);
	end

	assign rec = rec_q;

endmodule

// File: design/stable_bottom_up_merge_sorter_unit.sv
// top level of the stable sorter: load, odd-even transposition sort and drain
// over a chain of smsu_cell instances; depends on smsu_pkg and smsu_cell
//
// usage
//  - slave stream takes records: s_tdata = {tag, key}, s_tlast closes the set
//  - a set also closes when the record filling the last cell arrives
//  - loading takes one request per cycle; s_tready is low while sorting/draining
//  - after the closing request the chain runs n compare-exchange phases
//    (n = records in the set), one phase per cycle, then drains n records
//  - a set is loaded, sorted and drained before the next set is taken
//  - master stream gives sorted records from cell 0, m_tlast on the final one
//  - a stalled receiver simply holds the chain; nothing is lost
//  - equal keys never swap, so arrival order is kept on ties
//  - apb: byte 0 sort_descending, byte 4 signed_keys, bit 0 of the word
//  - reset clears the sequencer, counters and registers; cell contents are
//    left as they are and are always written before being read

module stable_bottom_up_merge_sorter_unit #(
	parameter int MAX_RECORDS = smsu_pkg::MAX_RECORDS_DEF,
	parameter int KEY_BITS    = smsu_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS    = smsu_pkg::TAG_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata fields from bit 0: record_key, record_tag, zero pad
	input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                                  s_tlast,
	// master stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// m_tdata fields from bit 0: sorted_key, sorted_tag, zero pad
	output logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                  m_tlast,
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	localparam int REC_W  = KEY_BITS + TAG_BITS;
	localparam int DATA_W = ((REC_W + 7) / 8) * 8;
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W  = $clog2(MAX_RECORDS);

	smsu_pkg::state_t state_q;
	logic [CNT_W-1:0] count_q;   // records in the set; remaining while draining
	logic [CNT_W-1:0] phase_q;   // sort phase
	logic             desc_q;
	logic             sgn_q;

	logic             in_hs;
	logic             out_hs;
	logic             cfg_wr;
	logic             closing;
	logic [REC_W-1:0] in_rec;

	logic [REC_W-1:0] rec    [MAX_RECORDS];
	logic             gt     [MAX_RECORDS];
	logic             swap   [MAX_RECORDS];

	// apb, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == smsu_pkg::REG_SIGNED_KEYS) ? {31'b0, sgn_q} : {31'b0, desc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
			sgn_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				smsu_pkg::REG_SORT_DESCENDING: desc_q <= pwdata[0];
				smsu_pkg::REG_SIGNED_KEYS:     sgn_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign s_tready = (state_q == smsu_pkg::ST_LOAD);
	assign m_tvalid = (state_q == smsu_pkg::ST_DRAIN);
	assign in_hs    = s_tvalid && s_tready;
	assign out_hs   = m_tvalid && m_tready;
	assign in_rec   = s_tdata[REC_W-1:0];
	assign closing  = s_tlast || (count_q == CNT_W'(MAX_RECORDS - 1));

	assign m_tdata  = DATA_W'(rec[0]);
	assign m_tlast  = (count_q == CNT_W'(1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smsu_pkg::ST_LOAD;
			count_q <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				smsu_pkg::ST_LOAD: begin
					if (in_hs) begin
						count_q <= count_q + CNT_W'(1);
						if (closing) begin
							phase_q <= '0;
							state_q <= smsu_pkg::ST_SORT;
						end
					end
				end
				smsu_pkg::ST_SORT: begin
					phase_q <= phase_q + CNT_W'(1);
					// n phases of odd-even transposition
					if (phase_q == count_q - CNT_W'(1)) begin
						state_q <= smsu_pkg::ST_DRAIN;
					end
				end
				smsu_pkg::ST_DRAIN: begin
					if (out_hs) begin
						count_q <= count_q - CNT_W'(1);
						if (m_tlast) begin
							state_q <= smsu_pkg::ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= smsu_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// pair i is (cell i, cell i+1); active on matching parity within the set
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_pair
		if (i < MAX_RECORDS - 1) begin : g_live
			assign swap[i] = (state_q == smsu_pkg::ST_SORT) && (phase_q[0] == 1'(i % 2))
				&& (CNT_W'(i + 1) < count_q) && gt[i];
		end else begin : g_end
			assign swap[i] = 1'b0;
		end
	end

	// the chain
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		smsu_pkg::cell_ctl_t ctl;
		logic [REC_W-1:0]    left_rec;
		logic [REC_W-1:0]    right_rec;

		if (i == 0) begin : g_first
			assign left_rec = '0;
			assign ctl.take_left = 1'b0;
		end else begin : g_mid
			assign left_rec = rec[i-1];
			assign ctl.take_left = swap[i-1];
		end
		if (i == MAX_RECORDS - 1) begin : g_last
			assign right_rec = '0;
		end else begin : g_inner
			assign right_rec = rec[i+1];
		end

		assign ctl.load        = in_hs && (count_q[IDX_W-1:0] == IDX_W'(i));
		// draining shifts the whole chain towards cell 0
		assign ctl.take_right  = swap[i] || out_hs;
		assign ctl.descending  = desc_q;
		assign ctl.signed_keys = sgn_q;

		smsu_cell #(
			.KEY_BITS(KEY_BITS),
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.load_rec (in_rec),
			.left_rec (left_rec),
			.right_rec(right_rec),
			.rec      (rec[i]),
			.gt_right (gt[i])
		);
	end

	// loading and draining never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("load and drain overlap");

	// the set never exceeds the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond chain length");

	// the final sorted record returns the block to loading with an empty set
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && m_tlast |=> s_tready && (count_q == '0))
		else $error("set not closed after final record");

	// a closing request always starts sorting
	a_close_sorts: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs && closing |=> (state_q == smsu_pkg::ST_SORT) && !s_tready)
		else $error("closing request did not start sort");

endmodule

// File: tb/testbench.sv
// self-checking bench for the stable merge sorter unit: record sets go in on the slave
// stream and every sorted record on the master stream is checked against a local predictor
// depends on smsu_pkg and stable_bottom_up_merge_sorter_unit

module testbench;

	localparam int CLK_HALF    = 6;
	localparam int KEY_W       = smsu_pkg::KEY_BITS_DEF;
	localparam int TAG_W       = smsu_pkg::TAG_BITS_DEF;
	localparam int SET_MAX     = smsu_pkg::MAX_RECORDS_DEF;
	localparam int DATA_W      = ((KEY_W + TAG_W + 7) / 8) * 8;
	localparam int SETTLE      = SET_MAX + 8;
	localparam int DRAIN_LIMIT = 20000;

	// how the keys of one random set are spread
	typedef enum int {
		SPREAD_FULL,
		SPREAD_TIES,
		SPREAD_SIGN
	} key_spread_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} record_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
	} sorted_rec_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// s_tdata fields from bit 0: record_key, record_tag
	logic [DATA_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	// m_tdata fields from bit 0: sorted_key, sorted_tag
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// predictor state: records of the set still being loaded, sorted records still expected and the order settings
	record_t     open_set[$];
	sorted_rec_t sorted_pending[$];
	logic        cfg_descending = 1'b0;
	logic        cfg_signed     = 1'b0;

	int error_count = 0;
	bit idling      = 1'b1;
	int stall_left  = 0;

	stable_bottom_up_merge_sorter_unit i_dut (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// true when key a may stand before key b; equal keys count as in order
	function automatic bit key_precedes(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic [KEY_W-1:0] ka = a;
		logic [KEY_W-1:0] kb = b;
		if (cfg_signed) begin
			// flipping the sign bit turns a two's complement order into an unsigned one
			ka[KEY_W-1] = ~ka[KEY_W-1];
			kb[KEY_W-1] = ~kb[KEY_W-1];
		end
		return cfg_descending ? (ka >= kb) : (ka <= kb);
	endfunction

	// stable insertion: a record only moves ahead of records it strictly precedes,
	// which gives the same order as a stable bottom-up merge
	function automatic void predict_sorted_set();
		record_t ordered[$];
		record_t rec;
		int      j;
		ordered = open_set;
		for (int i = 1; i < ordered.size(); i++) begin
			rec = ordered[i];
			j = i;
			while (j > 0 && !key_precedes(ordered[j-1].key, rec.key)) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = rec;
		end
		foreach (ordered[k])
			sorted_pending.push_back('{ordered[k].key, ordered[k].tag, k == ordered.size() - 1});
		open_set.delete();
	endfunction

	function automatic logic [KEY_W-1:0] random_key(input key_spread_t spread);
		logic [KEY_W-1:0] near = $urandom_range(0, 3);
		case (spread)
			SPREAD_FULL: return $urandom;
			// a few values around zero, so ties are common and signedness matters
			SPREAD_TIES: return near - 2;
			default:     return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fffc) + near;
		endcase
	endfunction

	// one request on the slave stream; valid stays high afterwards unless a gap follows
	task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
	                           input logic last);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tag, key};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		open_set.push_back('{key, tag});
		// the record that fills the store closes the set even without tlast
		if (last || open_set.size() == SET_MAX)
			predict_sorted_set();
	endtask

	// stop sending and let every expected record come out, then let the block settle
	task automatic drain_results();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (sorted_pending.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sorted_pending.size() != 0) begin
			report_mismatch($sformatf("%0d sorted records never arrived", sorted_pending.size()));
			sorted_pending.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write with its setup and access cycles, then a read back of the same register
	task automatic write_register(input logic index, input logic value);
		logic [31:0] word;
		word    = $urandom;
		word[0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (index == smsu_pkg::REG_SORT_DESCENDING)
			cfg_descending = value;
		else
			cfg_signed = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {31'b0, value})
			report_mismatch($sformatf("register at %0d reads %h, wrote %b",
				{index, 2'b00}, prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic descending, input logic as_signed);
		write_register(smsu_pkg::REG_SORT_DESCENDING, descending);
		write_register(smsu_pkg::REG_SIGNED_KEYS, as_signed);
	endtask

	// a set of one record comes straight back, marked last
	task automatic test_single_record();
		send_record('1, '1, 1'b1);
		send_record('0, '0, 1'b1);
		drain_results();
	endtask

	// key extremes, with a tie on zero, under every order setting
	task automatic test_order_extremes();
		logic [KEY_W-1:0] extreme_keys [5] =
			'{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
		for (int cfg = 0; cfg < 4; cfg++) begin
			configure(cfg[1], cfg[0]);
			for (int i = 0; i < 5; i++)
				send_record(extreme_keys[i], TAG_W'(cfg * 16 + i), i == 4);
			drain_results();
		end
	endtask

	// a full store closes the set on its own; the next records start a fresh set
	task automatic test_store_full();
		configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		for (int i = 0; i < SET_MAX; i++)
			send_record(random_key(SPREAD_TIES), TAG_W'(i), 1'b0);
		for (int i = 0; i < 5; i++)
			send_record(random_key(SPREAD_FULL), TAG_W'($urandom), i == 4);
		drain_results();
	endtask

	// settings written while a set is half loaded apply when that set closes
	task automatic test_config_mid_set();
		configure(1'b0, 1'b0);
		send_record(32'h8000_0001, 16'h0001, 1'b0);
		send_record(32'h0000_0005, 16'h0002, 1'b0);
		send_record(32'hffff_fffe, 16'h0003, 1'b0);
		drain_results();
		configure(1'b1, 1'b1);
		send_record(32'h0000_0005, 16'h0004, 1'b1);
		drain_results();
	endtask

	// random sets, mostly small, now and then a full store or an overflowing one
	task automatic test_random_sets(input int items);
		int          sent;
		int          size;
		key_spread_t spread;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 3) == 0) begin
				drain_results();
				configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			case ($urandom_range(0, 11))
				0:       size = SET_MAX;
				1:       size = $urandom_range(SET_MAX + 1, SET_MAX + 12);
				default: size = $urandom_range(1, 10);
			endcase
			spread = key_spread_t'($urandom_range(0, 2));
			for (int i = 0; i < size; i++)
				send_record(random_key(spread), TAG_W'($urandom), i == size - 1);
			sent += size;
		end
	endtask

	// the receiver drops m_tready for a random burst now and then while idling is on
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready   <= 1'b1;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 11);
			m_tready   <= 1'b0;
		end
	end

	// every accepted result request is held against the oldest expected record
	always @(posedge clk) begin : result_check
		sorted_rec_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (sorted_pending.size() == 0) begin
				report_mismatch($sformatf("unexpected record key %h tag %h last %b",
					m_tdata[KEY_W-1:0], m_tdata[KEY_W+TAG_W-1:KEY_W], m_tlast));
			end else begin
				want = sorted_pending.pop_front();
				if (m_tdata[KEY_W-1:0] !== want.key)
					report_mismatch($sformatf("sorted_key %h, expected %h",
						m_tdata[KEY_W-1:0], want.key));
				if (m_tdata[KEY_W+TAG_W-1:KEY_W] !== want.tag)
					report_mismatch($sformatf("sorted_tag %h, expected %h",
						m_tdata[KEY_W+TAG_W-1:KEY_W], want.tag));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_out %b, expected %b", m_tlast, want.last));
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_record();
		test_order_extremes();
		test_store_full();
		test_config_mid_set();
		test_random_sets(300);
		// closing stretch with both streams running flat out
		idling = 1'b0;
		test_random_sets(40);
		drain_results();

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// overall limit, far beyond the slowest correct run
	initial begin
		#(CLK_HALF * 2 * 400000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
